@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the min/max queue RTL.
// Needs i_clk, and for MMQ_ASSERT also i_rst_n, in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define MMQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check at every edge, reset included
`define MMQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/mmq_pkg.sv @@
// Types and constants of the min/max queue.
// No dependencies; used by mmq_ctrl, mmq_dp and min_max_queue_core.
package mmq_pkg;

    localparam int VALUE_W    = 16;
    localparam int TAG_W      = 16;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 112;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [TAG_W-1:0]   tag;
        logic signed [VALUE_W-1:0] hi;
        logic signed [VALUE_W-1:0] lo;
    } t_entry;

    typedef struct packed {
        logic load;
        logic reject;
        logic push_wr;
        logic pop_out;
        logic out_top_ld;
        logic move_start;
        logic move_rd;
        logic move_wr;
        logic move_end;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic out_zero;
        logic in_one;
        logic idx_one;
    } t_dp_sts;

endpackage

@@ rtl/core/mmq_ctrl.sv @@
// Sequencer of the min/max queue: request handshake and command steps.
// Depends on mmq_pkg; drives mmq_dp through t_dp_cmd.
module mmq_ctrl
    import mmq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EXEC      = 3'd1;
    localparam logic [2:0] S_OUT_LD    = 3'd2;
    localparam logic [2:0] S_MOVE      = 3'd3;
    localparam logic [2:0] S_MOVE_LAST = 3'd4;
    localparam logic [2:0] S_EMIT      = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_m_valid;
    logic       n_m_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_pop) begin
                    if (i_sts.empty) begin
                        o_cmd.reject = 1'b1;
                        n_state      = S_EMIT;
                    end else if (!i_sts.out_zero) begin
                        o_cmd.pop_out = 1'b1;
                        n_state       = S_OUT_LD;
                    end else if (i_sts.in_one) begin
                        o_cmd.move_end = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        o_cmd.move_start = 1'b1;
                        n_state          = S_MOVE;
                    end
                end else begin
                    if (i_sts.full) begin
                        o_cmd.reject = 1'b1;
                    end else begin
                        o_cmd.push_wr = 1'b1;
                    end
                    n_state = S_EMIT;
                end
            end
            S_OUT_LD: begin
                o_cmd.out_top_ld = 1'b1;
                n_state          = S_EMIT;
            end
            S_MOVE: begin
                o_cmd.move_rd = 1'b1;
                o_cmd.move_wr = 1'b1;
                if (i_sts.idx_one) begin
                    n_state = S_MOVE_LAST;
                end
            end
            S_MOVE_LAST: begin
                o_cmd.move_wr  = 1'b1;
                o_cmd.move_end = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule

@@ rtl/core/mmq_dp.sv @@
// Datapath of the min/max queue: both stack memories, depths, cached
// top and bottom entries and the result register. Depends on mmq_pkg.
module mmq_dp
    import mmq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    t_entry mem_in  [CAPACITY];
    t_entry mem_out [CAPACITY];

    logic                      r_cmd;
    logic signed [VALUE_W-1:0] r_value;
    logic        [TAG_W-1:0]   r_tag;
    logic                      r_rej;
    logic        [CNT_W-1:0]   r_in_depth;
    logic        [CNT_W-1:0]   r_out_depth;
    logic        [ADDR_W-1:0]  r_idx;
    logic                      r_wr_pend;
    t_entry                    r_in_top;
    t_entry                    r_in_bot;
    t_entry                    r_out_top;
    t_entry                    r_out_bot;
    t_entry                    r_in_rd;
    t_entry                    r_out_rd;
    logic [OUT_DATA_W-1:0]     r_tdata;

    logic   [CNT_W:0]   total;
    logic               in_nz;
    logic               out_nz;
    logic               out_wr;
    logic               out_rd;
    t_entry             push_entry;
    t_entry             move_entry;
    t_entry             front;
    t_entry             back;
    logic signed [VALUE_W-1:0] mx;
    logic signed [VALUE_W-1:0] mn;
    logic [OUT_DATA_W-1:0]     n_tdata;

    assign total  = {1'b0, r_in_depth} + {1'b0, r_out_depth};
    assign in_nz  = (r_in_depth != '0);
    assign out_nz = (r_out_depth != '0);
    assign out_wr = i_cmd.move_wr && r_wr_pend;
    assign out_rd = i_cmd.pop_out && (r_out_depth > CNT_W'(1));

    assign o_sts.is_pop   = (r_cmd == CMD_POP);
    assign o_sts.empty    = !in_nz && !out_nz;
    assign o_sts.full     = (total >= (CNT_W + 1)'(CAPACITY));
    assign o_sts.out_zero = !out_nz;
    assign o_sts.in_one   = (r_in_depth == CNT_W'(1));
    assign o_sts.idx_one  = (r_idx == ADDR_W'(1));

    always_comb begin
        push_entry.value = r_value;
        push_entry.tag   = r_tag;
        push_entry.hi    = (in_nz && r_in_top.hi > r_value) ? r_in_top.hi : r_value;
        push_entry.lo    = (in_nz && r_in_top.lo < r_value) ? r_in_top.lo : r_value;

        move_entry.value = r_in_rd.value;
        move_entry.tag   = r_in_rd.tag;
        move_entry.hi    = (out_nz && r_out_top.hi > r_in_rd.value) ? r_out_top.hi
                                                                  : r_in_rd.value;
        move_entry.lo    = (out_nz && r_out_top.lo < r_in_rd.value) ? r_out_top.lo
                                                                  : r_in_rd.value;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            mem_in[r_in_depth[ADDR_W-1:0]] <= push_entry;
        end
        if (i_cmd.move_rd) begin
            r_in_rd <= mem_in[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            mem_out[r_out_depth[ADDR_W-1:0]] <= move_entry;
        end
        if (out_rd) begin
            r_out_rd <= mem_out[ADDR_W'(r_out_depth - CNT_W'(2))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_depth  <= '0;
            r_out_depth <= '0;
            r_wr_pend   <= 1'b0;
        end else begin
            if (i_cmd.push_wr) begin
                r_in_depth <= r_in_depth + CNT_W'(1);
            end else if (i_cmd.move_end) begin
                r_in_depth <= '0;
            end
            if (i_cmd.pop_out) begin
                r_out_depth <= r_out_depth - CNT_W'(1);
            end else if (out_wr) begin
                r_out_depth <= r_out_depth + CNT_W'(1);
            end
            if (i_cmd.move_start) begin
                r_wr_pend <= 1'b0;
            end else if (i_cmd.move_rd) begin
                r_wr_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_s_tuser;
            r_value <= i_s_tdata[VALUE_W-1:0];
            r_tag   <= i_s_tdata[VALUE_W +: TAG_W];
        end
        if (i_cmd.load) begin
            r_rej <= 1'b0;
        end else if (i_cmd.reject) begin
            r_rej <= 1'b1;
        end
        if (i_cmd.move_start) begin
            r_idx <= ADDR_W'(r_in_depth - CNT_W'(1));
        end else if (i_cmd.move_rd) begin
            r_idx <= r_idx - ADDR_W'(1);
        end
        if (i_cmd.push_wr) begin
            r_in_top <= push_entry;
            if (!in_nz) begin
                r_in_bot <= push_entry;
            end
        end
        if (out_wr) begin
            r_out_top <= move_entry;
            if (!out_nz) begin
                r_out_bot <= move_entry;
            end
        end else if (i_cmd.out_top_ld) begin
            r_out_top <= r_out_rd;
        end
        if (i_cmd.emit) begin
            r_tdata <= n_tdata;
        end
    end

    always_comb begin
        front = out_nz ? r_out_top : r_in_bot;
        back  = in_nz ? r_in_top : r_out_bot;
        if (in_nz && out_nz) begin
            mx = (r_in_top.hi > r_out_top.hi) ? r_in_top.hi : r_out_top.hi;
            mn = (r_in_top.lo < r_out_top.lo) ? r_in_top.lo : r_out_top.lo;
        end else if (in_nz) begin
            mx = r_in_top.hi;
            mn = r_in_top.lo;
        end else begin
            mx = r_out_top.hi;
            mn = r_out_top.lo;
        end
        n_tdata = '0;
        if (!o_sts.empty) begin
            n_tdata[15:0]  = front.value;
            n_tdata[31:16] = front.tag;
            n_tdata[47:32] = back.value;
            n_tdata[63:48] = back.tag;
            n_tdata[79:64] = mx;
            n_tdata[95:80] = mn;
        end
        n_tdata[102:96] = COUNT_W'(total);
        n_tdata[103]    = o_sts.empty;
        n_tdata[104]    = r_rej;
    end

    assign o_m_tdata = r_tdata;

endmodule

@@ rtl/core/min_max_queue_core.sv @@
// Top level of the min/max queue: stream ports, sequencer and datapath.
// Depends on mmq_pkg, mmq_ctrl, mmq_dp and assert_macros.svh.
`include "assert_macros.svh"

// First-in first-out queue of (value, tag) items, up to CAPACITY of them,
// that answers every push or pop request with its front and back item,
// largest and smallest value, item count, an empty flag and a reject flag
// (push when full, pop when empty). It holds two stacks in two memories
// with one read and one write port each; every entry carries the running
// max and min below it. A push writes the input stack in its execute step
// and then emits its result; a pop from a non-empty output stack drops its
// top and reloads the cached top before it emits, and a pop that must refill
// the output stack moves one entry a cycle through the input stack's read
// port before it emits. A new request is taken while the previous result
// waits on the output side.
module min_max_queue_core
    import mmq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // value[15:0], tag[31:16]
    input  logic                  i_s_tuser,   // command[0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // front_value[15:0], front_tag[31:16],
                                               // back_value[47:32], back_tag[63:48],
                                               // max_value[79:64], min_value[95:80],
                                               // item_count[102:96], is_empty[103],
                                               // rejected[104], zero[111:105]
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    mmq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .o_m_tdata (o_m_tdata)
    );

    `MMQ_ASSERT(a_one_request, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "request overlap")
    `MMQ_ASSERT(a_valid_from_emit, $rose(o_m_tvalid) |-> $past(dp_cmd.emit), "stray result")
    `MMQ_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_m_tvalid && o_s_tready), "reset state")

endmodule
